// ===== hdl/rct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg - shared types and constants of the command tokenizer
// Result record, per-byte run of results, character codes and index limit.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int TokenIndexBits = 16;
  localparam logic [15:0] IdxLim = (TokenIndexBits >= 16) ? 16'hFFFF :
                                   16'((32'd1 << TokenIndexBits) - 32'd1);
  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseBit = 8'h20;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindDone = 2'd1,
    KindDrop = 2'd2,
    KindEnd  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [15:0] token_index;
    logic [15:0] token_count;
    logic        last_of_run;
  } rct_res_t;

  // results caused by one byte, up to four
  typedef struct packed {
    rct_res_t [3:0] ent;
    logic [2:0]     n;
  } rct_run_t;

endpackage

// ===== hdl/rct_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_step - tokenizer state and per-byte result generation
// Holds the message parse state and turns one byte into its run of results.
// ----------------------------------------------------------------------------
module rct_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output rct_pkg::rct_run_t run_o
);
  import rct_pkg::*;

  typedef enum logic [6:0] {
    PhStart  = 7'b0000001,
    PhCount  = 7'b0000010,
    PhLen    = 7'b0000100,
    PhData   = 7'b0001000,
    PhIgnore = 7'b0010000,
    PhGap    = 7'b0100000,
    PhToken  = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        cr_q, cr_d;
  logic [15:0] total_q, total_d;
  logic        neg_q, neg_d;
  logic        stop_q, stop_d;
  logic        started_q, started_d;
  logic [15:0] seen_q, seen_d;

  rct_run_t    run;
  logic        do_plain;
  logic [7:0]  digit;
  logic [19:0] prod;
  logic [15:0] line_total;
  logic [2:0]  last_pos;

  function automatic logic [15:0] idx_sat(input logic [15:0] seen);
    return (seen > IdxLim) ? IdxLim : seen;
  endfunction

  function automatic rct_res_t byte_res(input logic [7:0] b, input logic [15:0] seen);
    rct_res_t r;
    r             = '0;
    r.kind        = KindByte;
    r.out_byte    = (seen == 16'd0 && b >= ChLowA && b <= ChLowZ) ? b - CaseBit : b;
    r.token_index = idx_sat(seen);
    return r;
  endfunction

  function automatic rct_res_t mark_res(input kind_e k, input logic [15:0] seen);
    rct_res_t r;
    r             = '0;
    r.kind        = k;
    r.token_index = idx_sat(seen);
    return r;
  endfunction

  always_comb begin
    phase_d    = phase_q;
    cr_d       = cr_q;
    total_d    = total_q;
    neg_d      = neg_q;
    stop_d     = stop_q;
    started_d  = started_q;
    seen_d     = seen_q;
    run        = '0;
    do_plain   = 1'b0;
    digit      = byte_i - ChZero;
    prod       = {1'b0, total_q, 3'b000} + {3'b000, total_q, 1'b0} + {16'd0, digit[3:0]};
    line_total = neg_q ? 16'd0 : total_q;
    last_pos   = '0;

    unique case (phase_q)
      PhStart: begin
        if (byte_i == ChStar) begin
          phase_d = PhCount;
        end else begin
          phase_d  = PhGap;
          do_plain = 1'b1;
        end
      end
      PhCount, PhLen, PhData: begin
        if (cr_q && byte_i == ChLf) begin
          cr_d = 1'b0;
          if (phase_q == PhCount) begin
            total_d = line_total;
            phase_d = (line_total == 16'd0) ? PhIgnore : PhLen;
          end else if (phase_q == PhLen) begin
            phase_d = PhData;
          end else begin
            run.ent[run.n[1:0]] = mark_res(KindDone, seen_d);
            run.n = run.n + 3'd1;
            if (seen_d != CountMax) seen_d = seen_d + 16'd1;
            phase_d = (seen_d >= total_q) ? PhIgnore : PhLen;
          end
        end else begin
          // a held CR without LF is content
          if (cr_q) begin
            if (phase_q == PhCount) begin
              stop_d    = 1'b1;
              started_d = 1'b1;
            end else if (phase_q == PhData) begin
              run.ent[run.n[1:0]] = byte_res(ChCr, seen_d);
              run.n = run.n + 3'd1;
            end
          end
          cr_d = (byte_i == ChCr);
          if (byte_i != ChCr) begin
            if (phase_q == PhCount) begin
              if (!stop_d) begin
                if (byte_i >= ChZero && byte_i <= ChNine) begin
                  total_d = (prod > {4'd0, CountMax}) ? CountMax : prod[15:0];
                end else if (byte_i == ChMinus && !started_d) begin
                  neg_d = 1'b1;
                end else begin
                  stop_d = 1'b1;
                end
              end
              started_d = 1'b1;
            end else if (phase_q == PhData) begin
              run.ent[run.n[1:0]] = byte_res(byte_i, seen_d);
              run.n = run.n + 3'd1;
            end
          end
        end
      end
      PhGap, PhToken: begin
        do_plain = 1'b1;
      end
      PhIgnore: begin
      end
      default: begin
      end
    endcase

    if (do_plain) begin
      if (byte_i == ChSp || byte_i == ChCr || byte_i == ChLf) begin
        if (phase_d == PhToken) begin
          run.ent[run.n[1:0]] = mark_res(KindDone, seen_d);
          run.n = run.n + 3'd1;
          if (seen_d != CountMax) seen_d = seen_d + 16'd1;
        end
        phase_d = PhGap;
      end else begin
        run.ent[run.n[1:0]] = byte_res(byte_i, seen_d);
        run.n = run.n + 3'd1;
        phase_d = PhToken;
      end
    end

    if (last_i) begin
      if (phase_d == PhData) begin
        if (cr_d) begin
          run.ent[run.n[1:0]] = byte_res(ChCr, seen_d);
          run.n = run.n + 3'd1;
        end
        run.ent[run.n[1:0]] = mark_res(KindDrop, seen_d);
        run.n = run.n + 3'd1;
      end else if (phase_d == PhToken) begin
        run.ent[run.n[1:0]] = mark_res(KindDone, seen_d);
        run.n = run.n + 3'd1;
        if (seen_d != CountMax) seen_d = seen_d + 16'd1;
      end
      run.ent[run.n[1:0]]             = '0;
      run.ent[run.n[1:0]].kind        = KindEnd;
      run.ent[run.n[1:0]].token_count = seen_d;
      run.n = run.n + 3'd1;
      phase_d   = PhStart;
      cr_d      = 1'b0;
      total_d   = '0;
      neg_d     = 1'b0;
      stop_d    = 1'b0;
      started_d = 1'b0;
      seen_d    = '0;
    end

    if (run.n != 3'd0) begin
      last_pos = run.n - 3'd1;
      run.ent[last_pos[1:0]].last_of_run = 1'b1;
    end
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      cr_q      <= 1'b0;
      total_q   <= '0;
      neg_q     <= 1'b0;
      stop_q    <= 1'b0;
      started_q <= 1'b0;
      seen_q    <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      cr_q      <= cr_d;
      total_q   <= total_d;
      neg_q     <= neg_d;
      stop_q    <= stop_d;
      started_q <= started_d;
      seen_q    <= seen_d;
    end
  end

`ifndef ASSERT_OFF
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> phase_q == PhStart && seen_q == 16'd0 && !cr_q)
    else $error("parse state not cleared after message end");

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |-> run.n != 3'd0 && run.ent[last_pos[1:0]].kind == KindEnd)
    else $error("message end result missing or not last");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> run.n <= 3'd4)
    else $error("run holds more than four results");
`endif

endmodule

// ===== hdl/rct_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_out_buf - result register for one run of results
// Holds the results of one byte and presents them one transfer at a time.
// ----------------------------------------------------------------------------
module rct_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rct_pkg::rct_run_t run_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rct_pkg::rct_res_t res_o
);
  import rct_pkg::*;

  rct_res_t [3:0] ent_q;
  logic [2:0]     cnt_q, cnt_d;
  logic [1:0]     head_q, head_d;
  logic           take;

  assign out_valid_o = (cnt_q != 3'd0);
  assign take        = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready_i);
  assign res_o       = ent_q[head_q];

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = run_i.n;
      head_d = '0;
    end else if (take) begin
      cnt_d  = cnt_q - 3'd1;
      head_d = head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= run_i.ent;
    end
  end

`ifndef ASSERT_OFF
  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready_i))
    else $error("run loaded over pending results");

  a_run_tail_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd1 |-> res_o.last_of_run)
    else $error("final result of run lacks last mark");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !load_i |=> cnt_q == $past(cnt_q) - 3'd1)
    else $error("result count did not drop on transfer");
`endif

endmodule

// ===== hdl/resp_command_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_command_tokenizer - streaming tokenizer for key-value commands
// Splits RESP array or inline command messages into tagged token results.
// ----------------------------------------------------------------------------
// Input channel: one message byte per transfer on in_valid_i / in_ready_o,
// with last_byte_i on the final byte of each message.
// Output channel: one result per transfer on out_valid_o / out_ready_i:
// token byte, token complete, token dropped or message end, with
// last_of_run_o on the final result that a byte causes.
// Path: a byte taken into the input register is parsed there and its results
// are loaded into the output register, which presents the first of them.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; a byte giving more results (up to four) holds the
// input while the single output register drains one result per cycle.
// Reset: parse state returns to start of message, input and result
// registers empty. A stalled receiver holds the result; the input register
// takes one more byte, then in_ready_o drops until the run drains.
// ----------------------------------------------------------------------------
module resp_command_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] token_index_o,
  output logic [15:0] token_count_o,
  output logic        last_of_run_o
);
  import rct_pkg::*;

  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       can_load;
  logic       fire;
  rct_run_t   run;
  rct_res_t   res;

  assign fire       = vld_q && can_load;
  assign in_ready_o = !vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  rct_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .run_o  (run)
  );

  rct_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .run_i       (run),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign out_byte_o    = res.out_byte;
  assign token_index_o = res.token_index;
  assign token_count_o = res.token_count;
  assign last_of_run_o = res.last_of_run;

endmodule

// ===== test/tb_resp_command_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_command_tokenizer - self-checking bench for the command tokenizer
// Feeds RESP array and inline command messages byte by byte with random
// gaps on both channels, predicts every token result from a behavioural
// copy of the parser, and checks each result as it is taken.
// ----------------------------------------------------------------------------
module tb_resp_command_tokenizer;
  import rct_pkg::*;

  localparam int StallLimit = 500;
  localparam int ReportMax  = 10;
  localparam int RandBytes  = 310;

  typedef enum logic [2:0] {
    PhStart, PhCount, PhLen, PhData, PhIgnore, PhGap, PhToken
  } parse_phase_e;

  typedef struct {
    logic [7:0]  data;
    logic        last_b;
    int unsigned gap;
    int unsigned out_pace;
  } msg_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid_o;
  logic        out_ready;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] token_index_o;
  logic [15:0] token_count_o;
  logic        last_of_run_o;

  resp_command_tokenizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .token_index_o (token_index_o),
    .token_count_o (token_count_o),
    .last_of_run_o (last_of_run_o)
  );

  msg_byte_t   byte_stream_q[$];
  rct_res_t    token_results_q[$];
  rct_res_t    run_buf[$];
  logic [7:0]  msg_buf[$];

  parse_phase_e ph;
  logic         cr_held;
  logic [15:0]  elem_total;
  logic         cnt_neg;
  logic         cnt_stop;
  logic         cnt_started;
  logic [15:0]  tok_seen;

  logic        in_taken;
  logic        out_taken;
  int unsigned in_idle;
  int unsigned out_wait;
  int unsigned out_pace;
  int unsigned in_pace_gen;
  int unsigned out_pace_gen;
  int          mismatches;
  int          n_bytes;
  int          n_msgs;
  int          n_results;
  int          max_count;
  int          rand_bytes;

  // --------------------------------------------------------------------------
  // parser prediction
  // --------------------------------------------------------------------------
  function automatic logic [15:0] cur_index();
    return (tok_seen > IdxLim) ? IdxLim : tok_seen;
  endfunction

  function automatic void add_result(kind_e k, logic [7:0] b, logic [15:0] idx,
                                     logic [15:0] cnt);
    rct_res_t r;
    if (run_buf.size() >= 4) return;
    r.kind        = k;
    r.out_byte    = b;
    r.token_index = idx;
    r.token_count = cnt;
    r.last_of_run = 1'b0;
    run_buf.push_back(r);
  endfunction

  function automatic void add_token_byte(logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (tok_seen == 16'd0 && b >= ChLowA && b <= ChLowZ) c = b - CaseBit;
    add_result(KindByte, c, cur_index(), 16'd0);
  endfunction

  function automatic void finish_token();
    add_result(KindDone, 8'h00, cur_index(), 16'd0);
    if (tok_seen != CountMax) tok_seen = tok_seen + 16'd1;
  endfunction

  function automatic void clear_state();
    ph          = PhStart;
    cr_held     = 1'b0;
    elem_total  = 16'd0;
    cnt_neg     = 1'b0;
    cnt_stop    = 1'b0;
    cnt_started = 1'b0;
    tok_seen    = 16'd0;
  endfunction

  function automatic void line_content(logic [7:0] b);
    int unsigned t;
    if (ph == PhCount) begin
      if (!cnt_stop) begin
        if (b >= ChZero && b <= ChNine) begin
          t = 32'(elem_total) * 32'd10 + 32'(b - ChZero);
          elem_total = (t > 32'hFFFF) ? CountMax : t[15:0];
        end else if (b == ChMinus && !cnt_started) begin
          cnt_neg = 1'b1;
        end else begin
          cnt_stop = 1'b1;
        end
      end
      cnt_started = 1'b1;
    end else if (ph == PhData) begin
      add_token_byte(b);
    end
  endfunction

  function automatic void line_end();
    if (ph == PhCount) begin
      if (cnt_neg) elem_total = 16'd0;
      if (elem_total == 16'd0) ph = PhIgnore;
      else ph = PhLen;
    end else if (ph == PhLen) begin
      ph = PhData;
    end else if (ph == PhData) begin
      finish_token();
      if (tok_seen >= elem_total) ph = PhIgnore;
      else ph = PhLen;
    end
  endfunction

  function automatic void line_byte(logic [7:0] b);
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == ChLf) begin
        line_end();
        return;
      end
      line_content(ChCr);
    end
    if (b == ChCr) cr_held = 1'b1;
    else line_content(b);
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (b == ChSp || b == ChCr || b == ChLf) begin
      if (ph == PhToken) finish_token();
      ph = PhGap;
    end else begin
      add_token_byte(b);
      ph = PhToken;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic last_b);
    rct_res_t r;
    run_buf.delete();
    case (ph)
      PhStart: begin
        if (b == ChStar) begin
          ph = PhCount;
        end else begin
          ph = PhGap;
          plain_byte(b);
        end
      end
      PhCount, PhLen, PhData: line_byte(b);
      PhGap, PhToken: plain_byte(b);
      default: ;
    endcase
    if (last_b) begin
      if (ph == PhData) begin
        if (cr_held) add_token_byte(ChCr);
        add_result(KindDrop, 8'h00, cur_index(), 16'd0);
      end else if (ph == PhToken) begin
        finish_token();
      end
      add_result(KindEnd, 8'h00, 16'd0, tok_seen);
      clear_state();
    end
    foreach (run_buf[i]) begin
      r = run_buf[i];
      r.last_of_run = (i == run_buf.size() - 1);
      token_results_q.push_back(r);
    end
  endfunction

  function automatic void check_result();
    rct_res_t exp_r;
    if (token_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("unexpected result: kind %0d byte %02h idx %0d cnt %0d last %0b",
                 kind_o, out_byte_o, token_index_o, token_count_o, last_of_run_o);
      return;
    end
    exp_r = token_results_q.pop_front();
    n_results++;
    if (kind_o === KindEnd && token_count_o > max_count) max_count = token_count_o;
    if (kind_o !== exp_r.kind || out_byte_o !== exp_r.out_byte ||
        token_index_o !== exp_r.token_index || token_count_o !== exp_r.token_count ||
        last_of_run_o !== exp_r.last_of_run) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("result %0d: exp kind %0d byte %02h idx %0d cnt %0d last %0b, %s",
                 n_results, exp_r.kind, exp_r.out_byte, exp_r.token_index,
                 exp_r.token_count, exp_r.last_of_run,
                 $sformatf("got kind %0d byte %02h idx %0d cnt %0d last %0b",
                           kind_o, out_byte_o, token_index_o, token_count_o,
                           last_of_run_o));
    end
  endfunction

  // --------------------------------------------------------------------------
  // message building
  // --------------------------------------------------------------------------
  task automatic add_byte(logic [7:0] b);
    msg_buf.push_back(b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endtask

  task automatic add_num(int v);
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_crlf();
    msg_buf.push_back(ChCr);
    msg_buf.push_back(ChLf);
  endtask

  task automatic pick_pace();
    int unsigned sel;
    sel = $urandom_range(3);
    in_pace_gen = (sel == 0) ? 0 : (sel == 1) ? 3 : 13;
    sel = $urandom_range(3);
    out_pace_gen = (sel == 0) ? 0 : (sel == 1) ? 3 : 13;
  endtask

  // keep = 0 or keep not below the message length sends the whole message, otherwise it is cut after keep bytes
  task automatic flush_msg(int keep);
    msg_byte_t item;
    int n;
    n = (keep > 0 && keep < msg_buf.size()) ? keep : msg_buf.size();
    for (int i = 0; i < n; i++) begin
      item.data     = msg_buf[i];
      item.last_b   = (i == n - 1);
      item.gap      = $urandom_range(in_pace_gen);
      item.out_pace = out_pace_gen;
      byte_stream_q.push_back(item);
    end
    rand_bytes += n;
    msg_buf.delete();
  endtask

  function automatic logic [7:0] rand_content();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 5) return 8'($urandom_range(ChLowZ, ChLowA));
    if (sel == 6) return 8'($urandom_range(ChNine, ChZero));
    if (sel == 7) return ChCr;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_word_byte();
    logic [7:0] b;
    b = rand_content();
    while (b == ChSp || b == ChCr || b == ChLf) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic gen_resp();
    int n;
    int len;
    int total;
    int sel;
    n = $urandom_range(4, 1);
    add_byte(ChStar);
    sel = $urandom_range(9);
    if (sel == 0) add_text("-2");
    else if (sel == 1) add_text("7x");
    else if (sel == 2) add_text("70000");
    else add_num(n);
    add_crlf();
    for (int e = 0; e < n; e++) begin
      len = $urandom_range(6);
      add_byte(8'h24);
      add_num(len);
      add_crlf();
      for (int i = 0; i < len; i++) add_byte(rand_content());
      add_crlf();
    end
    if ($urandom_range(3) == 0)
      for (int i = 0; i < $urandom_range(3, 1); i++) add_byte(8'($urandom_range(255)));
    total = msg_buf.size();
    flush_msg(($urandom_range(4) == 0) ? $urandom_range(total, 1) : 0);
  endtask

  task automatic gen_plain();
    int n;
    if ($urandom_range(3) == 0) add_byte(ChSp);
    else add_byte(rand_word_byte());
    if (msg_buf[0] == ChStar) msg_buf[0] = 8'h41;
    n = $urandom_range(4, 1);
    for (int t = 0; t < n; t++) begin
      for (int i = 0; i < $urandom_range(4); i++) add_byte(rand_word_byte());
      if (t != n - 1 || $urandom_range(1) == 0)
        for (int i = 0; i < $urandom_range(2, 1); i++)
          case ($urandom_range(2))
            0: add_byte(ChSp);
            1: add_byte(ChCr);
            default: add_byte(ChLf);
          endcase
    end
    flush_msg(0);
  endtask

  task automatic gen_noise();
    if ($urandom_range(1) == 0) add_byte(ChStar);
    for (int i = 0; i < $urandom_range(6, 1); i++) add_byte(8'($urandom_range(255)));
    flush_msg(0);
  endtask

  // --------------------------------------------------------------------------
  // clock, reset and stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned sel;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    last_byte  = 1'b0;
    out_ready  = 1'b0;
    in_taken   = 1'b0;
    out_taken  = 1'b0;
    in_idle    = 0;
    out_wait   = 0;
    out_pace   = 0;
    mismatches = 0;
    n_bytes    = 0;
    n_msgs     = 0;
    n_results  = 0;
    max_count  = 0;
    rand_bytes = 0;
    clear_state();

    pick_pace();
    add_text("*2"); add_crlf(); add_text("$3"); add_crlf(); add_text("get"); add_crlf();
    add_text("$1"); add_crlf(); add_text("K"); add_crlf(); add_text("zz");
    flush_msg(0);
    add_text("set k"); add_byte(ChCr); add_text("v"); add_byte(ChLf);
    add_byte(8'h00); add_byte(8'hFF);
    flush_msg(0);
    add_text("*-3"); add_crlf(); add_text("q");
    flush_msg(0);
    add_text("*x"); add_crlf();
    flush_msg(0);
    add_text("*99999"); add_crlf(); add_text("$");
    flush_msg(0);
    add_text("*1"); add_crlf(); add_text("$2"); add_crlf();
    add_text("a"); add_byte(ChCr); add_text("b"); add_byte(ChCr);
    flush_msg(0);
    add_text("*1"); add_crlf(); add_text("$0"); add_crlf();
    flush_msg(0);
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf();
    add_text("b"); add_byte(ChCr); add_text("q");
    flush_msg(0);
    add_text("*12"); flush_msg(0);
    add_text("*"); flush_msg(0);
    add_text("hello"); flush_msg(0);
    add_text(" ab  c "); flush_msg(0);

    rand_bytes = 0;
    while (rand_bytes < RandBytes) begin
      pick_pace();
      sel = $urandom_range(9);
      if (sel <= 4) gen_resp();
      else if (sel <= 7) gen_plain();
      else gen_noise();
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_stream_q.size() != 0 || in_valid) @(negedge clk_i);
    while (token_results_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("covered %0d bytes in %0d messages, %0d results checked",
             n_bytes, n_msgs, n_results);
    $display("largest token count at message end: %0d, mismatches: %0d",
             max_count, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // byte driver and result ready
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed_bytes
    msg_byte_t nxt;
    if (rst_ni && (!in_valid || in_taken)) begin
      if (byte_stream_q.size() != 0 && in_idle >= byte_stream_q[0].gap) begin
        nxt = byte_stream_q.pop_front();
        data_byte <= nxt.data;
        last_byte <= nxt.last_b;
        out_pace  <= nxt.out_pace;
        in_valid  <= 1'b1;
        in_idle   <= 0;
      end else begin
        in_valid <= 1'b0;
        if (byte_stream_q.size() != 0) in_idle <= in_idle + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!out_ready || out_taken)) begin
      if (out_wait != 0) begin
        out_ready <= 1'b0;
        out_wait  <= out_wait - 1;
      end else begin
        out_ready <= 1'b1;
        out_wait  <= $urandom_range(out_pace);
      end
    end
  end

  // --------------------------------------------------------------------------
  // transfer monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid && in_ready_o;
      out_taken <= out_valid_o && out_ready;
      if (out_valid_o && out_ready) check_result();
      if (in_valid && in_ready_o) begin
        tokenize_byte(data_byte, last_byte);
        n_bytes++;
        if (last_byte) n_msgs++;
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("stalled for %0d cycles with work pending", StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rct_pkg.sv
hdl/rct_step.sv
hdl/rct_out_buf.sv
hdl/resp_command_tokenizer.sv
test/tb_resp_command_tokenizer.sv
